// File: rtl/sncag_pkg.sv
package sncag_pkg;

    localparam int MAX_DIMS     = 4;
    localparam int EXTENT_BITS  = 16;
    localparam int REG_BITS     = 64;
    localparam int DIM_OFF_BITS = 32;
    localparam int SUM_BITS     = DIM_OFF_BITS + $clog2(MAX_DIMS);
    localparam int EB_BITS      = 5;
    localparam int PROD_BITS    = SUM_BITS + EB_BITS;
    localparam int OFF_BITS     = 40;
    localparam int COUNT_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_EXTENTS   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_EXTENTS   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_STRIDES   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_STRIDES   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ELEMENT_BYTES = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ELEMENT_COUNT = 3'd5;

    localparam logic [REG_BITS-1:0] EXTENTS_RESET = 64'h0001_0001_0001_0001;

    typedef struct packed {
        logic load;     // an input transfer happens this cycle
        logic restart;  // walk starts again at element zero
        logic step;     // an element is issued, odometer advances
    } t_odo_ctrl;

    // Dimension field of a packed register; dims past the register get the absent value.
    function automatic logic [EXTENT_BITS-1:0] field_of(
        input logic [REG_BITS-1:0]    packed_v,
        input int unsigned            d,
        input logic [EXTENT_BITS-1:0] absent
    );
        logic [REG_BITS-1:0] shifted;
        shifted = packed_v >> (d * EXTENT_BITS);
        if (d * EXTENT_BITS >= REG_BITS) begin
            return absent;
        end
        return shifted[EXTENT_BITS-1:0];
    endfunction

endpackage

// File: rtl/sncag_odometer.sv
module sncag_odometer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sncag_pkg::t_odo_ctrl                i_ctrl,
    input  logic [sncag_pkg::REG_BITS-1:0]      i_extents,
    input  logic [sncag_pkg::REG_BITS-1:0]      i_strides,
    output logic [sncag_pkg::SUM_BITS-1:0]      o_offset_sum
);
    import sncag_pkg::*;

    logic [EXTENT_BITS-1:0]  r_coords [MAX_DIMS];
    logic [DIM_OFF_BITS-1:0] r_offs   [MAX_DIMS];
    logic [EXTENT_BITS-1:0]  base_c   [MAX_DIMS];
    logic [DIM_OFF_BITS-1:0] base_o   [MAX_DIMS];
    logic [EXTENT_BITS-1:0]  n_coords [MAX_DIMS];
    logic [DIM_OFF_BITS-1:0] n_offs   [MAX_DIMS];
    logic [EXTENT_BITS-1:0]  ext      [MAX_DIMS];
    logic [EXTENT_BITS-1:0]  str      [MAX_DIMS];
    logic [EXTENT_BITS:0]    inc      [MAX_DIMS];
    logic                    carry;
    logic [SUM_BITS-1:0]     sum;

    always_comb begin
        carry = 1'b1;
        sum   = '0;
        for (int unsigned d = 0; d < MAX_DIMS; d++) begin
            base_c[d] = i_ctrl.restart ? '0 : r_coords[d];
            base_o[d] = i_ctrl.restart ? '0 : r_offs[d];
            ext[d]    = field_of(i_extents, d, EXTENT_BITS'(1));
            str[d]    = field_of(i_strides, d, '0);
            inc[d]    = {1'b0, base_c[d]} + (EXTENT_BITS+1)'(1);
            sum       = sum + SUM_BITS'(base_o[d]);
            if (carry) begin
                if (inc[d] >= {1'b0, ext[d]}) begin
                    n_coords[d] = '0;
                    n_offs[d]   = '0;
                end else begin
                    n_coords[d] = inc[d][EXTENT_BITS-1:0];
                    n_offs[d]   = base_o[d] + DIM_OFF_BITS'(str[d]);
                    carry       = 1'b0;
                end
            end else begin
                n_coords[d] = base_c[d];
                n_offs[d]   = base_o[d];
            end
        end
    end

    assign o_offset_sum = sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_coords[d] <= '0;
                r_offs[d]   <= '0;
            end
        end else if (i_ctrl.load) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_coords[d] <= i_ctrl.step ? n_coords[d] : base_c[d];
                r_offs[d]   <= i_ctrl.step ? n_offs[d]   : base_o[d];
            end
        end
    end

endmodule

// File: rtl/strided_nd_copy_address_generator.sv
// An input transfer's result is registered in the s1 stage, then in the output
// stage, before the master side sees it. Throughput: one input transfer per cycle
// while the s1 stage is empty or can advance; the odometer carry chain and the element
// counter compare close in the input cycle, the scale by element size sits in the output stage.
// Reset (synchronous, active low): registers at their reset values, walk finished.
module strided_nd_copy_address_generator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [0] restart
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [2*sncag_pkg::OFF_BITS-1:0]      m_axis_tdata,  // {dst_byte_offset, src_byte_offset}
    output logic                                  m_axis_tlast,
    input  logic                                  i_cfg_we,
    input  logic [sncag_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [sncag_pkg::REG_BITS-1:0]        i_cfg_data
);
    import sncag_pkg::*;

    logic [REG_BITS-1:0]   r_src_ext, r_dst_ext, r_src_str, r_dst_str;
    logic [EB_BITS-1:0]    r_elem_bytes;
    logic [COUNT_BITS-1:0] r_elem_count;

    logic [COUNT_BITS-1:0] r_done;
    logic                  r_finished;

    logic                  r_s1_valid;
    logic [SUM_BITS-1:0]   r_s1_src_sum, r_s1_dst_sum;
    logic                  r_s1_last;

    logic                  r_out_valid;
    logic [OFF_BITS-1:0]   r_out_src, r_out_dst;
    logic                  r_out_last;

    logic                  en, acc, restart, fire, fin_base, last;
    logic [COUNT_BITS-1:0] done_base, n_done;
    logic [SUM_BITS-1:0]   src_sum, dst_sum;
    logic [PROD_BITS-1:0]  src_prod, dst_prod;
    t_odo_ctrl             odo_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_ext    <= EXTENTS_RESET;
            r_dst_ext    <= EXTENTS_RESET;
            r_src_str    <= '0;
            r_dst_str    <= '0;
            r_elem_bytes <= EB_BITS'(1);
            r_elem_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_EXTENTS:   r_src_ext    <= i_cfg_data;
                CFG_DST_EXTENTS:   r_dst_ext    <= i_cfg_data;
                CFG_SRC_STRIDES:   r_src_str    <= i_cfg_data;
                CFG_DST_STRIDES:   r_dst_str    <= i_cfg_data;
                CFG_ELEMENT_BYTES: r_elem_bytes <= i_cfg_data[EB_BITS-1:0];
                CFG_ELEMENT_COUNT: r_elem_count <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || en;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    assign done_base = restart ? '0 : r_done;
    assign fin_base  = restart ? (r_elem_count == '0) : r_finished;
    assign fire      = !fin_base;
    assign n_done    = done_base + COUNT_BITS'(1);
    assign last      = n_done >= r_elem_count;

    assign odo_ctrl.load    = acc;
    assign odo_ctrl.restart = restart;
    assign odo_ctrl.step    = fire;

    sncag_odometer u_src_odo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (odo_ctrl),
        .i_extents    (r_src_ext),
        .i_strides    (r_src_str),
        .o_offset_sum (src_sum)
    );

    sncag_odometer u_dst_odo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (odo_ctrl),
        .i_extents    (r_dst_ext),
        .i_strides    (r_dst_str),
        .o_offset_sum (dst_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= '0;
            r_finished <= 1'b1;
        end else if (acc) begin
            r_done     <= fire ? n_done : done_base;
            r_finished <= fire ? last : fin_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= acc && fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && fire) begin
            r_s1_src_sum <= src_sum;
            r_s1_dst_sum <= dst_sum;
            r_s1_last    <= last;
        end
    end

    assign src_prod = PROD_BITS'(r_s1_src_sum) * PROD_BITS'(r_elem_bytes);
    assign dst_prod = PROD_BITS'(r_s1_dst_sum) * PROD_BITS'(r_elem_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            r_out_src  <= OFF_BITS'(src_prod);
            r_out_dst  <= OFF_BITS'(dst_prod);
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_dst, r_out_src};
    assign m_axis_tlast  = r_out_last;

    a_finished_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished && !(acc && restart) |=> r_finished)
        else $error("walk left finished state without a restart");

    a_zero_count_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && restart && (r_elem_count == '0) |=> !r_s1_valid)
        else $error("restart with zero element count produced a transfer");

    a_last_sets_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last |-> r_finished)
        else $error("last element pending while walk not finished");

endmodule
